// ----- hw/rtl/robot_mode_supervisor_unit_macros.svh -----
// Assertion helpers for the mode supervisor
`ifndef ROBOT_MODE_SUPERVISOR_UNIT_MACROS_SVH
`define ROBOT_MODE_SUPERVISOR_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define RMS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rms: same-cycle check failed");

// Next-cycle implication, checked out of reset
`define RMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rms: next-cycle check failed");

`endif

// ----- hw/rtl/rms_pkg.sv -----
`default_nettype none

package rms_pkg;

    typedef enum logic [2:0] {
        MODE_INIT        = 3'd0,
        MODE_IDLE        = 3'd1,
        MODE_CALIBRATING = 3'd2,
        MODE_BALANCING   = 3'd3,
        MODE_FALLEN      = 3'd4,
        MODE_RECOVERY    = 3'd5,
        MODE_FATAL       = 3'd6
    } mode_t;

    typedef enum logic [3:0] {
        OP_FALL         = 4'd0,
        OP_START        = 4'd1,
        OP_STOP         = 4'd2,
        OP_BATTERY      = 4'd3,
        OP_ORIENT       = 4'd4,
        OP_CAL          = 4'd5,
        OP_CAL_DONE     = 4'd6,
        OP_SENSOR_ERR   = 4'd7,
        OP_REC_RESULT   = 4'd8,
        OP_REC_ON       = 4'd9,
        OP_REC_OFF      = 4'd10,
        OP_FALL_DET_ON  = 4'd11,
        OP_FALL_DET_OFF = 4'd12
    } op_t;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_UPRIGHT_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME_US      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPTS      = 2'd2;

    localparam logic [14:0] THRESHOLD_RESET    = 15'd715;
    localparam logic [31:0] HOLD_TIME_RESET    = 32'd1000000;
    localparam logic [3:0]  MAX_ATTEMPTS_RESET = 4'd3;
    localparam logic [3:0]  ATTEMPT_MAX        = 4'd15;

    typedef struct packed {
        logic [3:0]         operation;
        logic               battery_low;
        logic signed [15:0] pitch;
        logic [63:0]        timestamp_us;
        logic               recovery_ok;
    } in_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [2:0] previous_mode;
        logic       mode_changed;
        logic       calibration_request;
        logic       recovery_request;
        logic [3:0] attempt_number;
    } out_t;

endpackage

`default_nettype wire

// ----- hw/rtl/robot_mode_supervisor_unit.sv -----
// Each event is held in the input register, and its result in the output register.
// Throughput: one event per cycle while results are taken; a stalled result holds the next
// event in the input register, and input stalls once both registers are full.
// Reset (rst_n low, asynchronous): mode init, saved mode idle, tracker and attempt
// count cleared, auto-recovery and fall detection on, registers at their defaults.
`default_nettype none
`include "robot_mode_supervisor_unit_macros.svh"

module robot_mode_supervisor_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wen,
    input  wire logic [rms_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  wire logic [rms_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire rms_pkg::in_t                    in_data,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output rms_pkg::out_t                        out_data
);

    // configuration
    logic [14:0] threshold_reg;
    logic [31:0] hold_time_reg;
    logic [3:0]  max_attempts_reg;

    // pipeline
    logic          s1_valid_reg;
    logic          s1_valid_next;
    rms_pkg::in_t  s1_data_reg;
    logic          s1_take;
    logic          in_fire;
    logic          out_valid_reg;
    logic          out_valid_next;
    rms_pkg::out_t out_data_reg;
    rms_pkg::out_t out_data_next;

    // supervisor state
    rms_pkg::mode_t mode_reg;
    rms_pkg::mode_t mode_next;
    rms_pkg::mode_t saved_reg;
    rms_pkg::mode_t saved_next;
    logic           trk_reg;
    logic           trk_next;
    logic [63:0]    start_reg;
    logic [63:0]    start_next;
    logic [3:0]     count_reg;
    logic [3:0]     count_next;
    logic           auto_reg;
    logic           auto_next;
    logic           fd_reg;
    logic           fd_next;

    assign in_fire   = in_valid && in_ready;
    assign s1_take   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || s1_take;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_take)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (s1_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // event decode and mode transition
    always_comb
    begin
        logic [15:0] p_raw;
        logic [15:0] p_neg;
        logic [14:0] mag;
        logic [63:0] elapsed;
        logic        held;
        logic        clr;
        logic        step_req;
        logic        changed;
        logic        cal_req;
        logic        rec_req;

        p_raw    = s1_data_reg.pitch;
        p_neg    = ~p_raw + 16'd1;
        elapsed  = s1_data_reg.timestamp_us - start_reg;
        held     = (elapsed[63:32] != 32'd0) || (elapsed[31:0] >= hold_time_reg);
        clr      = 1'b0;
        step_req = 1'b0;
        cal_req  = 1'b0;
        rec_req  = 1'b0;

        mode_next  = mode_reg;
        saved_next = saved_reg;
        trk_next   = trk_reg;
        start_next = start_reg;
        count_next = count_reg;
        auto_next  = auto_reg;
        fd_next    = fd_reg;

        // saturate the magnitude of the most negative pitch
        if (!p_raw[15])
        begin
            mag = p_raw[14:0];
        end
        else if (p_raw == 16'h8000)
        begin
            mag = 15'h7FFF;
        end
        else
        begin
            mag = p_neg[14:0];
        end

        unique case (rms_pkg::op_t'(s1_data_reg.operation))
            rms_pkg::OP_FALL:
            begin
                if (fd_reg && mode_reg == rms_pkg::MODE_BALANCING)
                begin
                    mode_next = rms_pkg::MODE_FALLEN;
                end
            end
            rms_pkg::OP_START:
            begin
                if (mode_reg == rms_pkg::MODE_IDLE || mode_reg == rms_pkg::MODE_FALLEN)
                begin
                    mode_next = rms_pkg::MODE_BALANCING;
                end
            end
            rms_pkg::OP_STOP:
            begin
                mode_next = rms_pkg::MODE_IDLE;
            end
            rms_pkg::OP_BATTERY:
            begin
                if (s1_data_reg.battery_low && mode_reg == rms_pkg::MODE_BALANCING)
                begin
                    mode_next = rms_pkg::MODE_IDLE;
                end
            end
            rms_pkg::OP_ORIENT:
            begin
                if (mode_reg != rms_pkg::MODE_FALLEN || !auto_reg)
                begin
                    clr = 1'b1;
                end
                else if (mag < threshold_reg)
                begin
                    if (!trk_reg)
                    begin
                        trk_next   = 1'b1;
                        start_next = s1_data_reg.timestamp_us;
                    end
                    else if (held)
                    begin
                        mode_next = rms_pkg::MODE_BALANCING;
                    end
                end
                else
                begin
                    clr = 1'b1;
                end
            end
            rms_pkg::OP_CAL:
            begin
                if (mode_reg == rms_pkg::MODE_IDLE)
                begin
                    mode_next = rms_pkg::MODE_CALIBRATING;
                    cal_req   = 1'b1;
                end
            end
            rms_pkg::OP_CAL_DONE:
            begin
                if (mode_reg == rms_pkg::MODE_CALIBRATING)
                begin
                    mode_next = rms_pkg::MODE_IDLE;
                end
            end
            rms_pkg::OP_SENSOR_ERR:
            begin
                if (mode_reg != rms_pkg::MODE_RECOVERY && mode_reg != rms_pkg::MODE_FATAL)
                begin
                    saved_next = mode_reg;
                    mode_next  = rms_pkg::MODE_RECOVERY;
                end
            end
            rms_pkg::OP_REC_RESULT:
            begin
                if (mode_reg == rms_pkg::MODE_RECOVERY)
                begin
                    if (s1_data_reg.recovery_ok)
                    begin
                        mode_next = saved_reg;
                    end
                    else if (count_reg >= max_attempts_reg)
                    begin
                        mode_next = rms_pkg::MODE_FATAL;
                    end
                    else
                    begin
                        step_req = 1'b1;
                    end
                end
            end
            rms_pkg::OP_REC_ON:
            begin
                auto_next = 1'b1;
            end
            rms_pkg::OP_REC_OFF:
            begin
                auto_next = 1'b0;
                clr       = 1'b1;
            end
            rms_pkg::OP_FALL_DET_ON:
            begin
                fd_next = 1'b1;
            end
            rms_pkg::OP_FALL_DET_OFF:
            begin
                fd_next = 1'b0;
            end
            default:
            begin
                // unused codes leave everything as it is
            end
        endcase

        changed = (mode_next != mode_reg);

        // side effects of a mode change, tracker clears and retry steps
        if (changed && mode_reg == rms_pkg::MODE_FALLEN)
        begin
            clr = 1'b1;
        end
        if (clr)
        begin
            trk_next = 1'b0;
        end

        if (changed && mode_next == rms_pkg::MODE_RECOVERY)
        begin
            // entry always starts a fresh count with attempt one
            count_next = 4'd1;
            rec_req    = 1'b1;
        end
        else if (changed && mode_reg == rms_pkg::MODE_RECOVERY)
        begin
            count_next = 4'd0;
        end
        else if (step_req)
        begin
            if (count_reg != rms_pkg::ATTEMPT_MAX)
            begin
                count_next = count_reg + 4'd1;
            end
            rec_req = 1'b1;
        end

        out_data_next.mode                = mode_next;
        out_data_next.previous_mode       = mode_reg;
        out_data_next.mode_changed        = changed;
        out_data_next.calibration_request = cal_req;
        out_data_next.recovery_request    = rec_req;
        out_data_next.attempt_number      = rec_req ? count_next : 4'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg    <= rms_pkg::THRESHOLD_RESET;
            hold_time_reg    <= rms_pkg::HOLD_TIME_RESET;
            max_attempts_reg <= rms_pkg::MAX_ATTEMPTS_RESET;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_addr)
                rms_pkg::CFG_UPRIGHT_THRESHOLD: threshold_reg    <= cfg_wdata[14:0];
                rms_pkg::CFG_HOLD_TIME_US:      hold_time_reg    <= cfg_wdata;
                rms_pkg::CFG_MAX_ATTEMPTS:      max_attempts_reg <= cfg_wdata[3:0];
                default:
                begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= rms_pkg::MODE_INIT;
            saved_reg     <= rms_pkg::MODE_IDLE;
            trk_reg       <= 1'b0;
            count_reg     <= 4'd0;
            auto_reg      <= 1'b1;
            fd_reg        <= 1'b1;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_take)
            begin
                mode_reg  <= mode_next;
                saved_reg <= saved_next;
                trk_reg   <= trk_next;
                count_reg <= count_next;
                auto_reg  <= auto_next;
                fd_reg    <= fd_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_data_reg <= in_data;
        end
        if (s1_take)
        begin
            out_data_reg <= out_data_next;
            start_reg    <= start_next;
        end
    end

    `RMS_ASSERT_IMPL(a_count_only_in_recovery, clk, rst_n,
        count_reg != 4'd0, mode_reg == rms_pkg::MODE_RECOVERY)
    `RMS_ASSERT_IMPL(a_tracking_only_fallen, clk, rst_n,
        trk_reg, mode_reg == rms_pkg::MODE_FALLEN)
    `RMS_ASSERT_IMPL(a_request_in_recovery, clk, rst_n,
        out_valid_reg && out_data_reg.recovery_request,
        out_data_reg.mode == rms_pkg::MODE_RECOVERY && out_data_reg.attempt_number != 4'd0)
    `RMS_ASSERT_NEXT(a_take_gives_result, clk, rst_n,
        s1_take, out_valid_reg)

endmodule

`default_nettype wire

// ----- tb/rms_mode_checker.sv -----
`default_nettype none

module rms_mode_checker
    import rms_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wen,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  in_t                   in_data,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  out_t                  out_data,
    output int                    fail_count,
    output int                    pending,
    output int                    results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    // register copies
    logic [14:0] thr;
    logic [31:0] hold_us;
    logic [3:0]  attempt_limit;

    // supervisor state
    mode_t       mode_now;
    mode_t       mode_saved;
    logic        tracking;
    logic [63:0] upright_since;
    logic [3:0]  attempts;
    logic        recover_en;
    logic        fall_det_en;

    // per-event flags
    logic        ev_changed;
    logic        ev_rec_req;
    logic [3:0]  ev_attempt;

    out_t reports_due[$];

    task automatic clear_tracker();
        tracking = 1'b0;
        upright_since = '0;
    endtask

    task automatic next_attempt();
        if (attempts < ATTEMPT_MAX)
        begin
            attempts = attempts + 4'd1;
        end
        ev_rec_req = 1'b1;
        ev_attempt = attempts;
    endtask

    task automatic enter_mode(input mode_t target);
        mode_t was;
        was = mode_now;
        if (target != was)
        begin
            mode_now = target;
            ev_changed = 1'b1;
            if (was == MODE_FALLEN)
            begin
                clear_tracker();
            end
            if (was == MODE_RECOVERY)
            begin
                attempts = '0;
            end
            if (target == MODE_RECOVERY)
            begin
                next_attempt();
            end
        end
    endtask

    task automatic supervise_event(input in_t ev, output out_t res);
        mode_t       was;
        logic [15:0] raw;
        logic [15:0] mag;
        logic        cal_req;
        was = mode_now;
        cal_req = 1'b0;
        ev_changed = 1'b0;
        ev_rec_req = 1'b0;
        ev_attempt = '0;
        case (ev.operation)
            OP_FALL:
                if (fall_det_en && mode_now == MODE_BALANCING)
                begin
                    enter_mode(MODE_FALLEN);
                end
            OP_START:
                if (mode_now == MODE_IDLE || mode_now == MODE_FALLEN)
                begin
                    enter_mode(MODE_BALANCING);
                end
            OP_STOP:
                enter_mode(MODE_IDLE);
            OP_BATTERY:
                if (ev.battery_low && mode_now == MODE_BALANCING)
                begin
                    enter_mode(MODE_IDLE);
                end
            OP_ORIENT:
            begin
                // saturate |pitch|: the most negative code reads as the most positive
                raw = ev.pitch;
                if (raw == 16'h8000)
                begin
                    mag = 16'h7FFF;
                end
                else if (raw[15])
                begin
                    mag = -raw;
                end
                else
                begin
                    mag = raw;
                end
                if (mode_now != MODE_FALLEN || !recover_en)
                begin
                    clear_tracker();
                end
                else if (mag < {1'b0, thr})
                begin
                    if (!tracking)
                    begin
                        tracking = 1'b1;
                        upright_since = ev.timestamp_us;
                    end
                    else if (ev.timestamp_us - upright_since >= {32'd0, hold_us})
                    begin
                        enter_mode(MODE_BALANCING);
                    end
                end
                else
                begin
                    clear_tracker();
                end
            end
            OP_CAL:
                if (mode_now == MODE_IDLE)
                begin
                    enter_mode(MODE_CALIBRATING);
                    cal_req = 1'b1;
                end
            OP_CAL_DONE:
                if (mode_now == MODE_CALIBRATING)
                begin
                    enter_mode(MODE_IDLE);
                end
            OP_SENSOR_ERR:
                if (mode_now != MODE_RECOVERY && mode_now != MODE_FATAL)
                begin
                    mode_saved = mode_now;
                    attempts = '0;
                    enter_mode(MODE_RECOVERY);
                end
            OP_REC_RESULT:
                if (mode_now == MODE_RECOVERY)
                begin
                    if (ev.recovery_ok)
                    begin
                        enter_mode(mode_saved);
                    end
                    else if (attempts >= attempt_limit)
                    begin
                        enter_mode(MODE_FATAL);
                    end
                    else
                    begin
                        next_attempt();
                    end
                end
            OP_REC_ON:
                recover_en = 1'b1;
            OP_REC_OFF:
            begin
                recover_en = 1'b0;
                clear_tracker();
            end
            OP_FALL_DET_ON:
                fall_det_en = 1'b1;
            OP_FALL_DET_OFF:
                fall_det_en = 1'b0;
            default:
                ;
        endcase
        res.mode                = mode_now;
        res.previous_mode       = was;
        res.mode_changed        = ev_changed;
        res.calibration_request = cal_req;
        res.recovery_request    = ev_rec_req;
        res.attempt_number      = ev_attempt;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        out_t want;
        if (!rst_n)
        begin
            thr = THRESHOLD_RESET;
            hold_us = HOLD_TIME_RESET;
            attempt_limit = MAX_ATTEMPTS_RESET;
            mode_now = MODE_INIT;
            mode_saved = MODE_IDLE;
            tracking = 1'b0;
            upright_since = '0;
            attempts = '0;
            recover_en = 1'b1;
            fall_det_en = 1'b1;
            reports_due.delete();
            fail_count = 0;
            results_seen = 0;
        end
        else
        begin
            if (cfg_wen)
            begin
                case (cfg_addr)
                    CFG_UPRIGHT_THRESHOLD: thr = cfg_wdata[14:0];
                    CFG_HOLD_TIME_US:      hold_us = cfg_wdata;
                    CFG_MAX_ATTEMPTS:      attempt_limit = cfg_wdata[3:0];
                    default:               ;
                endcase
            end
            // retire the oldest expectation before queueing the new transfer
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (reports_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("%0t: result with nothing pending: mode %0d prev %0d", $realtime,
                                 out_data.mode, out_data.previous_mode);
                    end
                end
                else
                begin
                    want = reports_due.pop_front();
                    if (out_data.mode !== want.mode
                        || out_data.previous_mode !== want.previous_mode
                        || out_data.mode_changed !== want.mode_changed
                        || out_data.calibration_request !== want.calibration_request
                        || out_data.recovery_request !== want.recovery_request
                        || out_data.attempt_number !== want.attempt_number)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("%0t: mismatch exp mode %0d prev %0d chg %0b cal %0b req %0b n %0d",
                                     $realtime, want.mode, want.previous_mode, want.mode_changed,
                                     want.calibration_request, want.recovery_request,
                                     want.attempt_number);
                            $display("%0t:          got mode %0d prev %0d chg %0b cal %0b req %0b n %0d",
                                     $realtime, out_data.mode, out_data.previous_mode,
                                     out_data.mode_changed, out_data.calibration_request,
                                     out_data.recovery_request, out_data.attempt_number);
                        end
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                supervise_event(in_data, want);
                reports_due.push_back(want);
            end
        end
        pending = reports_due.size();
    end

endmodule

`default_nettype wire

// ----- tb/tb_robot_mode_supervisor_unit.sv -----
`default_nettype none

module tb_robot_mode_supervisor_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import rms_pkg::*;

    localparam int          QUIET_LIMIT = 4000;
    localparam int          LONG_HOLD   = 300;
    localparam logic [3:0]  OP_NONE     = 4'd15;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wen = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    in_t                   in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_t                  out_data;

    int fail_count;
    int pending;
    int results_seen;

    int          sender_idle_pct = 0;
    int          stall_pct = 0;
    bit          long_hold_req = 1'b0;
    int          hold_left = 0;
    int          quiet_cycles = 0;
    int          items_sent = 0;
    int          settings_count = 0;
    logic [14:0] cur_thr = THRESHOLD_RESET;
    logic [31:0] cur_hold = HOLD_TIME_RESET;
    logic [63:0] now_us = '0;

    robot_mode_supervisor_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    rms_mode_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wen      (cfg_wen),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen)
    );

    always #5 clk = ~clk;

    // result side: random stalls, plus one long hold-off on request
    always @(negedge clk)
    begin
        if (long_hold_req)
        begin
            long_hold_req = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Timeout after %0d quiet cycles, %0d results pending", quiet_cycles,
                         pending);
                $display("FAIL robot_mode_supervisor_unit");
                $finish;
            end
        end
    end

    task automatic send_event(input in_t ev);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= ev;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    task automatic post(input logic [3:0] op, input logic bl, input logic [15:0] p,
                        input logic [63:0] ts, input logic ok);
        in_t ev;
        ev.operation = op;
        ev.battery_low = bl;
        ev.pitch = p;
        ev.timestamp_us = ts;
        ev.recovery_ok = ok;
        send_event(ev);
    endtask

    function automatic in_t random_event(input logic [3:0] op);
        in_t ev;
        ev.operation = op;
        ev.battery_low = $urandom_range(1);
        ev.pitch = 16'($urandom);
        ev.timestamp_us = {$urandom, $urandom};
        ev.recovery_ok = $urandom_range(1);
        return ev;
    endfunction

    function automatic logic [15:0] pick_pitch(input bit upright);
        logic [15:0] m;
        if (upright && cur_thr != 0)
        begin
            m = 16'($urandom_range(cur_thr - 1));
            return $urandom_range(1) ? -m : m;
        end
        else if ($urandom_range(7) == 0)
        begin
            return 16'h8000;
        end
        return 16'($urandom);
    endfunction

    // step the sample clock around the hold time; hold minus one may wrap backwards
    task automatic advance_clock();
        case ($urandom_range(5))
            0: now_us = now_us;
            1: now_us = now_us + 64'd1;
            2: now_us = now_us + {33'd0, cur_hold[31:1]};
            3: now_us = now_us + {32'd0, cur_hold};
            4: now_us = now_us + {32'd0, cur_hold} - 64'd1;
            default: now_us = now_us + {32'd0, cur_hold} + 64'($urandom_range(1000));
        endcase
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_wen <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_wen <= 1'b0;
    endtask

    task automatic settle_pipeline();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic play_episode();
        in_t ev;
        int  roll;
        int  n;
        roll = $urandom_range(99);
        if (roll < 35)
        begin
            // fall, then a run of orientation samples toward auto-recovery
            if ($urandom_range(3) == 0)
            begin
                send_event(random_event(OP_FALL_DET_ON));
            end
            if ($urandom_range(3) == 0)
            begin
                send_event(random_event(OP_REC_ON));
            end
            send_event(random_event(OP_STOP));
            send_event(random_event(OP_START));
            send_event(random_event(OP_FALL));
            n = $urandom_range(2, 8);
            repeat (n)
            begin
                advance_clock();
                ev = random_event(OP_ORIENT);
                ev.pitch = pick_pitch($urandom_range(9) < 8);
                ev.timestamp_us = now_us;
                send_event(ev);
            end
        end
        else if (roll < 55)
        begin
            // sensor error, a string of failed attempts, maybe a success
            if ($urandom_range(1))
            begin
                send_event(random_event(OP_STOP));
            end
            if ($urandom_range(1))
            begin
                send_event(random_event(OP_START));
            end
            send_event(random_event(OP_SENSOR_ERR));
            n = $urandom_range(16);
            repeat (n)
            begin
                ev = random_event(OP_REC_RESULT);
                ev.recovery_ok = 1'b0;
                send_event(ev);
            end
            if ($urandom_range(1))
            begin
                ev = random_event(OP_REC_RESULT);
                ev.recovery_ok = 1'b1;
                send_event(ev);
            end
        end
        else if (roll < 65)
        begin
            send_event(random_event(OP_STOP));
            send_event(random_event(OP_CAL));
            if ($urandom_range(2) == 0)
            begin
                send_event(random_event(4'($urandom_range(15))));
            end
            send_event(random_event(OP_CAL_DONE));
        end
        else if (roll < 75)
        begin
            send_event(random_event(OP_START));
            send_event(random_event(OP_BATTERY));
        end
        else if (roll < 85)
        begin
            send_event(random_event(4'($urandom_range(OP_REC_ON, OP_FALL_DET_OFF))));
            send_event(random_event(OP_FALL));
        end
        else
        begin
            n = $urandom_range(1, 4);
            repeat (n)
            begin
                send_event(random_event(4'($urandom_range(15))));
            end
        end
    endtask

    task automatic run_phase(input logic [14:0] thr, input logic [31:0] hold,
                             input logic [3:0] max_a, input int idle_p, input int stall_p,
                             input int n, input bit squeeze);
        int target;
        write_reg(CFG_UPRIGHT_THRESHOLD, {17'd0, thr});
        write_reg(CFG_HOLD_TIME_US, hold);
        write_reg(CFG_MAX_ATTEMPTS, {28'd0, max_a});
        cur_thr = thr;
        cur_hold = hold;
        settings_count++;
        sender_idle_pct = idle_p;
        stall_pct = stall_p;
        now_us = {$urandom, $urandom};
        if (squeeze)
        begin
            long_hold_req = 1'b1;
        end
        target = items_sent + n;
        while (items_sent < target)
        begin
            play_episode();
        end
        settle_pipeline();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed pass at reset register values
        post(OP_NONE, 1'b1, 16'h7FFF, '1, 1'b1);
        post(OP_REC_RESULT, 1'b0, 16'h0000, '0, 1'b1);
        post(OP_STOP, 1'b0, 16'h0000, '0, 1'b0);
        post(OP_STOP, 1'b0, 16'h0000, '0, 1'b0);
        post(OP_CAL, 1'b0, 16'h0000, '0, 1'b0);
        post(OP_CAL_DONE, 1'b0, 16'h0000, '0, 1'b0);
        post(OP_START, 1'b0, 16'h0000, '0, 1'b0);
        post(OP_BATTERY, 1'b0, 16'h0000, '0, 1'b0);
        post(OP_FALL, 1'b0, 16'h0000, '0, 1'b0);
        post(OP_ORIENT, 1'b0, 16'h0000, 64'hFFFF_FFFF_FFFF_FF00, 1'b0);
        post(OP_ORIENT, 1'b0, 16'h8000, 64'hFFFF_FFFF_FFFF_FF10, 1'b0);
        post(OP_ORIENT, 1'b0, 16'h7FFF, 64'hFFFF_FFFF_FFFF_FF20, 1'b0);
        post(OP_ORIENT, 1'b0, 16'hFD36, 64'hFFFF_FFFF_FFFF_FF9C, 1'b0);
        // elapsed time wraps through zero and lands exactly on the hold time
        post(OP_ORIENT, 1'b0, 16'd714, 64'd999_900, 1'b0);
        post(OP_FALL_DET_OFF, 1'b0, 16'h0000, '0, 1'b0);
        post(OP_FALL, 1'b0, 16'h0000, '0, 1'b0);
        post(OP_FALL_DET_ON, 1'b0, 16'h0000, '0, 1'b0);
        post(OP_FALL, 1'b0, 16'h0000, '0, 1'b0);
        post(OP_REC_OFF, 1'b0, 16'h0000, '0, 1'b0);
        post(OP_REC_ON, 1'b0, 16'h0000, '0, 1'b0);
        post(OP_START, 1'b0, 16'h0000, '0, 1'b0);
        post(OP_BATTERY, 1'b1, 16'h0000, '0, 1'b0);
        post(OP_SENSOR_ERR, 1'b0, 16'h0000, '0, 1'b0);
        post(OP_REC_RESULT, 1'b0, 16'h0000, '0, 1'b0);
        post(OP_REC_RESULT, 1'b0, 16'h0000, '0, 1'b0);
        post(OP_REC_RESULT, 1'b0, 16'h0000, '0, 1'b0);
        post(OP_SENSOR_ERR, 1'b0, 16'h0000, '0, 1'b0);
        post(OP_STOP, 1'b0, 16'h0000, '0, 1'b0);
        settle_pipeline();

        run_phase(15'd715, 32'd1000, 4'd3, 0, 0, 205, 1'b0);
        run_phase(15'd32767, 32'd0, 4'd15, 50, 0, 205, 1'b0);
        run_phase(15'd0, 32'hFFFF_FFFF, 4'd0, 0, 50, 205, 1'b0);
        run_phase(15'($urandom_range(32767)), 32'($urandom_range(1, 5000)), 4'd1, 20, 20, 205,
                  1'b0);
        run_phase(15'd4096, 32'd500, 4'd15, 0, 0, 205, 1'b1);
        run_phase(15'd1, 32'd1, 4'd7, 20, 20, 205, 1'b0);

        repeat (6) @(posedge clk);
        $display("Run covered %0d events under %0d register settings, %0d results compared",
                 items_sent, settings_count, results_seen);
        $display("Traffic mixed free flow, sender gaps, receiver stalls and one long hold-off");
        if (fail_count == 0 && pending == 0)
        begin
            $display("PASS robot_mode_supervisor_unit");
        end
        else
        begin
            $display("FAIL robot_mode_supervisor_unit");
        end
        $finish;
    end

endmodule

`default_nettype wire
